FILE: rtl/core/hcfb_pkg.sv
// Shared types, constants and saturation helpers of the HID command frame builder.
package hcfb_pkg;

	localparam logic [7:0] HDR0     = 8'h57;
	localparam logic [7:0] HDR1     = 8'hAB;
	localparam logic [7:0] CMD_INFO = 8'h01;
	localparam logic [7:0] CMD_KEYB = 8'h02;
	localparam logic [7:0] CMD_ABS  = 8'h04;
	localparam logic [7:0] CMD_REL  = 8'h05;

	localparam logic [7:0] ABS_TAG  = 8'h02;
	localparam logic [7:0] REL_TAG  = 8'h01;

	localparam logic [3:0] LEN_INFO = 4'd0;
	localparam logic [3:0] LEN_KEYB = 4'd8;
	localparam logic [3:0] LEN_ABS  = 4'd7;
	localparam logic [3:0] LEN_REL  = 4'd5;

	// Byte position of the first payload byte within a frame
	localparam logic [3:0] PLD_START = 4'd5;

	localparam int unsigned PLD_MAX = 8;

	localparam logic signed [15:0] ABS_MIN = 16'sd1;
	localparam logic signed [15:0] ABS_MAX = 16'sd4095;
	localparam logic signed [15:0] REL_MIN = -16'sd128;
	localparam logic signed [15:0] REL_MAX = 16'sd127;

	typedef enum logic [1:0] {
		OP_INFO = 2'd0,
		OP_KEYB = 2'd1,
		OP_ABS  = 2'd2,
		OP_REL  = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} state_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
		logic [7:0]         buttons;
		logic signed [7:0]  wheel;
		logic [7:0]         modifiers;
		logic [7:0]         key_code;
	} cmd_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} frame_byte_t;

	function automatic logic [15:0] sat_abs(logic signed [15:0] v);
		logic [15:0] r;
		if (v < ABS_MIN) begin
			r = ABS_MIN;
		end else if (v > ABS_MAX) begin
			r = ABS_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [7:0] sat_rel(logic signed [15:0] v);
		logic [7:0] r;
		if (v < REL_MIN) begin
			r = REL_MIN[7:0];
		end else if (v > REL_MAX) begin
			r = REL_MAX[7:0];
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/hcfb_if.sv
// Valid/ready channel interfaces of the HID command frame builder.
interface hcfb_cmd_if;
	logic              valid;
	logic              ready;
	hcfb_pkg::cmd_t    payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface hcfb_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface hcfb_frame_if;
	logic                  valid;
	logic                  ready;
	hcfb_pkg::frame_byte_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/hid_command_frame_builder.sv
// Top level: turns one HID command into a serial frame, one byte per transfer.
// Each command accepted on cmd produces a frame of 6 (info query), 14 (keyboard),
// 13 (absolute mouse) or 11 (relative mouse) bytes on frame: 0x57, 0xAB, the
// device address, the command code, the payload length, the payload and an
// additive checksum, the last flagged by last_byte. A sequencer walks the byte
// index and one shared 8-bit adder builds the checksum as bytes go out, one byte
// a cycle while frame.ready holds, and cmd.ready stays low until its checksum
// byte is in the output register.
// The device address register is written through cfg and is always ready.
module hid_command_frame_builder (
	input  logic          clk,
	input  logic          arst_n,
	hcfb_cmd_if.sink      cmd,
	hcfb_cfg_if.sink      cfg,
	hcfb_frame_if.source  frame
);
	import hcfb_pkg::*;

	state_t      state_q, state_d;
	logic [7:0]  addr_q;
	logic [7:0]  cmd_code_q;
	logic [3:0]  len_q;
	logic [7:0]  pld_q [PLD_MAX];
	logic [3:0]  idx_q;
	logic [7:0]  sum_q;
	logic [7:0]  tx_byte_q;
	logic        last_q;
	logic        out_valid_q;

	logic        accept;
	logic        load;
	logic        is_last;
	logic [2:0]  pld_idx;
	logic [7:0]  byte_sel;
	logic [7:0]  cmd_code_d;
	logic [3:0]  len_d;
	logic [7:0]  pld_d [PLD_MAX];
	logic [15:0] abs_x, abs_y;
	logic [7:0]  rel_x, rel_y;

	assign accept  = cmd.valid && cmd.ready;
	assign is_last = (idx_q == len_q + PLD_START);
	assign pld_idx = 3'(idx_q - PLD_START);

	// Payload of the incoming command, saturated per mode
	always_comb begin
		abs_x = sat_abs(cmd.payload.x_coord);
		abs_y = sat_abs(cmd.payload.y_coord);
		rel_x = sat_rel(cmd.payload.x_coord);
		rel_y = sat_rel(cmd.payload.y_coord);
		for (int i = 0; i < PLD_MAX; i++) begin
			pld_d[i] = 8'h00;
		end
		unique case (cmd.payload.op)
			OP_INFO: begin
				cmd_code_d = CMD_INFO;
				len_d      = LEN_INFO;
			end
			OP_KEYB: begin
				cmd_code_d = CMD_KEYB;
				len_d      = LEN_KEYB;
				pld_d[0]   = cmd.payload.modifiers;
				pld_d[2]   = cmd.payload.key_code;
			end
			OP_ABS: begin
				cmd_code_d = CMD_ABS;
				len_d      = LEN_ABS;
				pld_d[0]   = ABS_TAG;
				pld_d[1]   = cmd.payload.buttons;
				pld_d[2]   = abs_x[7:0];
				pld_d[3]   = abs_x[15:8];
				pld_d[4]   = abs_y[7:0];
				pld_d[5]   = abs_y[15:8];
				pld_d[6]   = cmd.payload.wheel;
			end
			OP_REL: begin
				cmd_code_d = CMD_REL;
				len_d      = LEN_REL;
				pld_d[0]   = REL_TAG;
				pld_d[1]   = cmd.payload.buttons;
				pld_d[2]   = rel_x;
				pld_d[3]   = rel_y;
				pld_d[4]   = cmd.payload.wheel;
			end
			default: begin
				cmd_code_d = CMD_INFO;
				len_d      = LEN_INFO;
			end
		endcase
	end

	// Byte at the current frame position
	always_comb begin
		if (is_last) begin
			byte_sel = sum_q;
		end else begin
			unique case (idx_q)
				4'd0:    byte_sel = HDR0;
				4'd1:    byte_sel = HDR1;
				4'd2:    byte_sel = addr_q;
				4'd3:    byte_sel = cmd_code_q;
				4'd4:    byte_sel = {4'd0, len_q};
				default: byte_sel = pld_q[pld_idx];
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (load && is_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd.ready             = (state_q == ST_IDLE);
		cfg.ready             = 1'b1;
		load                  = (state_q == ST_SEND) && (!out_valid_q || frame.ready);
		frame.valid           = out_valid_q;
		frame.payload.tx_byte = tx_byte_q;
		frame.payload.last_byte = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			addr_q      <= 8'h00;
			idx_q       <= 4'd0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				addr_q <= cfg.payload;
			end
			if (accept) begin
				idx_q <= 4'd0;
			end else if (load) begin
				idx_q <= idx_q + 4'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_code_q <= cmd_code_d;
			len_q      <= len_d;
			pld_q      <= pld_d;
			sum_q      <= 8'h00;
		end else if (load) begin
			// advance the running checksum with the byte being loaded into the output register
			sum_q <= sum_q + byte_sel;
		end
		if (load) begin
			tx_byte_q <= byte_sel;
			last_q    <= is_last;
		end
	end

endmodule
